FILE: hdl/ntt_pkg.sv
// Shared types, constants and modular helpers for the NTT unit.
package ntt_pkg;

  // Modulus and fixed constants of the transform.
  localparam int unsigned Q          = 3329;
  localparam int unsigned ROOT       = 17;
  localparam int unsigned INV_SCALE  = 3303;
  localparam int unsigned ZETA_COUNT = 128;
  // Barrett reduction: m = floor(2^26 / q) leaves at most one correction.
  localparam int unsigned BARRETT_M  = 20158;
  localparam int unsigned BARRETT_SH = 26;

  typedef logic [11:0] coef_t;
  typedef logic [ZETA_COUNT-1:0][11:0] zeta_tbl_t;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRANS = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Kind codes of a result word.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration register index.
  localparam logic REG_DIRECTION = 1'b0;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDW,
    ST_OUT,
    ST_RA,
    ST_RB,
    ST_CAP,
    ST_BRD,
    ST_MULW,
    ST_WA,
    ST_WB,
    ST_SRD,
    ST_SWT,
    ST_SMW
  } state_t;

  // Request to and response from the shared modular multiplier.
  typedef struct packed {
    logic  start;
    coef_t a;
    coef_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    coef_t value;
  } mul_rsp_t;

  // Powers of the root, worked out at elaboration.
  function automatic zeta_tbl_t make_zetas();
    zeta_tbl_t   t;
    int unsigned p;
    p = 1;
    for (int m = 0; m < ZETA_COUNT; m++) begin
      t[m] = coef_t'(p);
      p = (p * ROOT) % Q;
    end
    return t;
  endfunction

  localparam zeta_tbl_t ZETA_TABLE = make_zetas();

  // Addition modulo q of two reduced residues.
  function automatic coef_t mod_add(coef_t a, coef_t b);
    logic [12:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 13'(Q)) ? coef_t'(s - 13'(Q)) : coef_t'(s);
  endfunction

  // Subtraction modulo q of two reduced residues.
  function automatic coef_t mod_sub(coef_t a, coef_t b);
    logic [12:0] d;
    d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + 13'(Q) - {1'b0, b});
    return coef_t'(d);
  endfunction

endpackage

FILE: hdl/ntt_q3329_forward_inverse_unit.sv
// Top level of the NTT unit: sequencer, coefficient store and configuration port.
//
// The unit holds 256 coefficients modulo 3329. Input words carry an operation:
// load writes a coefficient (values of 3329 and above are reduced once), read
// returns one as a result word of kind 0, and transform rewrites the whole store
// with the forward NTT (direction 0) or the inverse NTT scaled by 3303
// (direction 1), then gives one result word of kind 1 with value zero.
// Operation code 3 is accepted and ignored.
// A load is written to the store at acceptance. A read passes through a read-wait
// and an output state before its result word appears. A transform runs 896
// butterflies through one shared store port pair and one shared four-stage
// multiplier; the inverse adds a scaling pass over every coefficient.
// in_ready is high only while the sequencer is idle.
// Results sit in an output register; a load is still taken while a result
// waits, and a stalled receiver holds the sequencer at its final step.
// Reset clears the control state and sets direction to forward; the store is
// undefined until written. The direction register is at byte address 0.
module ntt_q3329_forward_inverse_unit #(
  parameter int COEFF_COUNT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_operation,
  input  logic [$clog2(COEFF_COUNT)-1:0] in_index,
  input  logic [11:0]                    in_coefficient,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [11:0]                    out_value,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  localparam int IDX_W = $clog2(COEFF_COUNT);
  localparam int K_W   = IDX_W - 1;
  localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(COEFF_COUNT / 2);
  localparam logic [IDX_W-1:0] LEN_MIN = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(COEFF_COUNT - 1);

  ntt_pkg::state_t state_r, state_nxt;
  logic                dir_r;
  logic                inv_r, inv_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [IDX_W-1:0]    len_r, len_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [11:0]         a_r, a_nxt;
  logic [11:0]         b_r, b_nxt;
  logic [11:0]         t_r, t_nxt;
  logic                pend_kind_r, pend_kind_nxt;
  logic [11:0]         pend_value_r, pend_value_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [11:0]         out_value_r, out_value_nxt;

  logic                we;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [11:0]         wdata, rdata;
  ntt_pkg::mul_req_t   mreq;
  ntt_pkg::mul_rsp_t   mrsp;

  logic                in_acc;
  logic                cfg_wr;
  logic [11:0]         load_val;
  logic [K_W-1:0]      k_rev;
  logic [11:0]         zeta;
  logic [IDX_W-1:0]    j_hi;
  logic [IDX_W:0]      j_step;
  logic                grp_last;

  assign in_acc = in_valid && in_ready;
  assign in_ready = (state_r == ntt_pkg::ST_IDLE);

  // Configuration port: one register, always ready.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == ntt_pkg::REG_DIRECTION;
  assign cfg_prdata = (cfg_paddr[2] == ntt_pkg::REG_DIRECTION) ? {31'd0, dir_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_wr) begin
      dir_r <= cfg_pwdata[0];
    end
  end

  // Coefficient store and shared multiplier.
  ntt_ram #(.WIDTH(12), .DEPTH(COEFF_COUNT)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ntt_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // Loaded value reduced once, twiddle lookup and butterfly index step.
  assign load_val = (in_coefficient >= 12'(ntt_pkg::Q)) ?
                    12'(in_coefficient - 12'(ntt_pkg::Q)) : in_coefficient;
  assign k_rev    = {<<{k_r}};
  assign zeta     = ntt_pkg::ZETA_TABLE[k_rev];
  assign j_hi     = j_r + len_r;
  assign grp_last = ((j_r & (len_r - IDX_W'(1))) == (len_r - IDX_W'(1)));
  assign j_step   = grp_last ? ({1'b0, j_r} + {1'b0, len_r} + (IDX_W+1)'(1))
                             : ({1'b0, j_r} + (IDX_W+1)'(1));

  // Control and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ntt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    inv_r        <= inv_nxt;
    j_r          <= j_nxt;
    len_r        <= len_nxt;
    k_r          <= k_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    t_r          <= t_nxt;
    pend_kind_r  <= pend_kind_nxt;
    pend_value_r <= pend_value_nxt;
    out_kind_r   <= out_kind_nxt;
    out_value_r  <= out_value_nxt;
  end

  // Sequencer: next state, store access and multiplier requests.
  always_comb begin
    state_nxt      = state_r;
    inv_nxt        = inv_r;
    j_nxt          = j_r;
    len_nxt        = len_r;
    k_nxt          = k_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    t_nxt          = t_r;
    pend_kind_nxt  = pend_kind_r;
    pend_value_nxt = pend_value_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_value_nxt  = out_value_r;
    we             = 1'b0;
    waddr          = j_r;
    wdata          = a_r;
    raddr          = j_r;
    mreq.start     = 1'b0;
    mreq.a         = zeta;
    mreq.b         = rdata;

    // The output register empties when the receiver takes the word.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ntt_pkg::ST_IDLE: begin
        raddr = in_index;
        if (in_acc) begin
          case (ntt_pkg::op_t'(in_operation))
            ntt_pkg::OP_LOAD: begin
              we    = 1'b1;
              waddr = in_index;
              wdata = load_val;
            end
            ntt_pkg::OP_TRANS: begin
              inv_nxt   = dir_r;
              j_nxt     = '0;
              len_nxt   = dir_r ? LEN_MIN : LEN_MAX;
              k_nxt     = dir_r ? {K_W{1'b1}} : K_W'(1);
              state_nxt = ntt_pkg::ST_RA;
            end
            ntt_pkg::OP_READ: begin
              state_nxt = ntt_pkg::ST_RDW;
            end
            default: begin
            end
          endcase
        end
      end
      ntt_pkg::ST_RDW: begin
        pend_kind_nxt  = ntt_pkg::KIND_READ;
        pend_value_nxt = rdata;
        state_nxt      = ntt_pkg::ST_OUT;
      end
      ntt_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_value_nxt = pend_value_r;
          state_nxt     = ntt_pkg::ST_IDLE;
        end
      end
      ntt_pkg::ST_RA: begin
        state_nxt = ntt_pkg::ST_RB;
      end
      ntt_pkg::ST_RB: begin
        // The lower operand arrives now; the upper one is requested.
        a_nxt     = rdata;
        raddr     = j_hi;
        state_nxt = ntt_pkg::ST_CAP;
      end
      ntt_pkg::ST_CAP: begin
        raddr     = j_hi;
        state_nxt = ntt_pkg::ST_BRD;
      end
      ntt_pkg::ST_BRD: begin
        b_nxt      = rdata;
        mreq.start = 1'b1;
        mreq.b     = inv_r ? ntt_pkg::mod_sub(rdata, a_r) : rdata;
        state_nxt  = ntt_pkg::ST_MULW;
      end
      ntt_pkg::ST_MULW: begin
        if (mrsp.done) begin
          t_nxt     = mrsp.value;
          state_nxt = ntt_pkg::ST_WA;
        end
      end
      ntt_pkg::ST_WA: begin
        we        = 1'b1;
        wdata     = inv_r ? ntt_pkg::mod_add(a_r, b_r) : ntt_pkg::mod_add(a_r, t_r);
        state_nxt = ntt_pkg::ST_WB;
      end
      ntt_pkg::ST_WB: begin
        we    = 1'b1;
        waddr = j_hi;
        wdata = inv_r ? t_r : ntt_pkg::mod_sub(a_r, t_r);
        j_nxt = j_step[IDX_W-1:0];
        if (grp_last) begin
          k_nxt = inv_r ? (k_r - K_W'(1)) : (k_r + K_W'(1));
        end
        state_nxt = ntt_pkg::ST_RA;
        // End of a layer: move to the next length or finish the pass.
        if (j_step[IDX_W]) begin
          j_nxt = '0;
          if (inv_r) begin
            len_nxt = IDX_W'({len_r, 1'b0});
            if (len_r == LEN_MAX) begin
              state_nxt = ntt_pkg::ST_SRD;
            end
          end else begin
            len_nxt = len_r >> 1;
            if (len_r == LEN_MIN) begin
              pend_kind_nxt  = ntt_pkg::KIND_DONE;
              pend_value_nxt = '0;
              state_nxt      = ntt_pkg::ST_OUT;
            end
          end
        end
      end
      ntt_pkg::ST_SRD: begin
        state_nxt = ntt_pkg::ST_SWT;
      end
      ntt_pkg::ST_SWT: begin
        mreq.start = 1'b1;
        mreq.a     = 12'(ntt_pkg::INV_SCALE);
        state_nxt  = ntt_pkg::ST_SMW;
      end
      ntt_pkg::ST_SMW: begin
        if (mrsp.done) begin
          we    = 1'b1;
          wdata = mrsp.value;
          j_nxt = j_r + IDX_W'(1);
          if (j_r == IDX_LAST) begin
            pend_kind_nxt  = ntt_pkg::KIND_DONE;
            pend_value_nxt = '0;
            state_nxt      = ntt_pkg::ST_OUT;
          end else begin
            state_nxt = ntt_pkg::ST_SRD;
          end
        end
      end
      default: begin
        state_nxt = ntt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;

endmodule

FILE: hdl/ntt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ntt_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/ntt_modmul.sv
// Shared four-stage modular multiplier with Barrett reduction.
module ntt_modmul (
  input  logic              clk,
  input  logic              rst_n,
  input  ntt_pkg::mul_req_t req,
  output ntt_pkg::mul_rsp_t rsp
);

  logic [3:0]  v_r;
  logic [23:0] p_r;
  logic [38:0] e_r;
  logic [12:0] r_r;
  logic [11:0] res_r;
  logic [12:0] qe;
  logic [24:0] qprod;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], req.start};
    end
  end

  // Quotient estimate and its product with q.
  assign qe    = e_r[38:ntt_pkg::BARRETT_SH];
  assign qprod = 25'(qe * 12'(ntt_pkg::Q));

  // Product, estimate, remainder and final correction, each in its own register stage.
  always_ff @(posedge clk) begin
    if (req.start) begin
      p_r <= req.a * req.b;
    end
    if (v_r[0]) begin
      e_r <= p_r * 15'(ntt_pkg::BARRETT_M);
    end
    if (v_r[1]) begin
      r_r <= 13'({1'b0, p_r} - qprod);
    end
    if (v_r[2]) begin
      res_r <= (r_r >= 13'(ntt_pkg::Q)) ? 12'(r_r - 13'(ntt_pkg::Q)) : r_r[11:0];
    end
  end

  assign rsp.done  = v_r[3];
  assign rsp.value = res_r;

endmodule

FILE: hdl/ntt_checker.sv
// Port-level assertions for the NTT unit and the bind that attaches them.
module ntt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [11:0] out_value,
  input logic [31:0] cfg_prdata
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
    else $error("result word changed while stalled");

  // A finished-transform word always carries zero.
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ntt_pkg::KIND_DONE |-> out_value == 12'd0)
    else $error("transform-finished word with non-zero value");

  // Every result word carries a reduced residue.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value < 12'(ntt_pkg::Q))
    else $error("result value not reduced");

  // A transform or read occupies the sequencer for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == ntt_pkg::OP_TRANS ||
    in_operation == ntt_pkg::OP_READ) |=> !in_ready)
    else $error("input taken while a transform or read is in progress");

  // Only the direction bit reads back as non-zero.
  a_prdata: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_prdata[31:1] == 31'd0)
    else $error("unused register bits read as non-zero");

endmodule

bind ntt_q3329_forward_inverse_unit ntt_checker u_ntt_checker (.*);
